[src/bbr_pkg.sv]
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`timescale 1ns / 1ps

package bbr_pkg;

  // Field widths fixed by the pixel and result formats
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned OUT_COL_W  = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned RCP_W      = 17;
  localparam int unsigned RCP_SHIFT  = 16;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // Input item
  typedef struct packed {
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;
  } bbr_in_t;

  // Result item
  typedef struct packed {
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic [CHAN_W-1:0]    out_blue;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_red;
    logic                 run_last;
  } bbr_out_t;

  // One stored pixel, as kept in the line stores and the window
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // Window control from the sequencer
  typedef struct packed {
    logic shift_en;   // take in a new column
    logic sum_en;     // register the masked sums
    logic up_row;     // result sits one row above the item
    logic left_col;   // result sits one column left of the item
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
  } win_ctrl_t;

  // Masked channel sums and the number of pixels that went in
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sb;
    logic [SUM_W-1:0] sg;
    logic [SUM_W-1:0] sr;
  } sum_t;

  // Rounded-up 2^16/cnt; exact truncated quotient for sums below 2296
  function automatic logic [RCP_W-1:0] recip_f(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    case (cnt)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

[src/bbr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bbr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bbr_window.sv]
// 3x3 pixel window with masked per-channel sums over in-frame neighbors.
`timescale 1ns / 1ps

module bbr_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbr_pkg::win_ctrl_t ctrl_i,
  input  bbr_pkg::pix_t      up_i,
  input  bbr_pkg::pix_t      mid_i,
  input  bbr_pkg::pix_t      px_i,
  output bbr_pkg::sum_t      sum_o
);
  import bbr_pkg::*;

  pix_t       win_q [9];
  sum_t       sum_d;
  sum_t       sum_q;
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic [1:0] nrows;
  logic [1:0] ncols;

  // Shift the window left by one column on each new item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 9; j++) begin
        win_q[j] <= '0;
      end
    end else if (ctrl_i.shift_en) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= up_i;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid_i;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= px_i;
    end
  end

  // Keep rows and columns that are both near the result and inside the frame
  always_comb begin
    row_ok = {1'b1, ctrl_i.row_ge1, ctrl_i.up_row & ctrl_i.row_ge2};
    col_ok = {1'b1, ctrl_i.col_ge1, ctrl_i.left_col & ctrl_i.col_ge2};
    nrows  = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
    ncols  = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
    sum_d  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (row_ok[i] && col_ok[k]) begin
          sum_d.sb = sum_d.sb + SUM_W'(win_q[i*3+k].blue);
          sum_d.sg = sum_d.sg + SUM_W'(win_q[i*3+k].green);
          sum_d.sr = sum_d.sr + SUM_W'(win_q[i*3+k].red);
        end
      end
    end
    sum_d.cnt = CNT_W'(nrows) * CNT_W'(ncols);
  end

  // Hold the sums for the divide stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

[src/bbr_mean.sv]
// Divide the three channel sums by the pixel count via reciprocal multiply.
`timescale 1ns / 1ps

module bbr_mean (
  input  logic           clk_i,
  input  logic           en_i,
  input  bbr_pkg::sum_t  sum_i,
  output bbr_pkg::pix_t  mean_o
);
  import bbr_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RCP_W;

  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] prod_b_q;
  logic [PROD_W-1:0] prod_g_q;
  logic [PROD_W-1:0] prod_r_q;

  assign rcp = recip_f(sum_i.cnt);

  // Register the products; the shift below takes the quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_b_q <= PROD_W'(sum_i.sb) * PROD_W'(rcp);
      prod_g_q <= PROD_W'(sum_i.sg) * PROD_W'(rcp);
      prod_r_q <= PROD_W'(sum_i.sr) * PROD_W'(rcp);
    end
  end

  assign mean_o.blue  = CHAN_W'(prod_b_q >> RCP_SHIFT);
  assign mean_o.green = CHAN_W'(prod_g_q >> RCP_SHIFT);
  assign mean_o.red   = CHAN_W'(prod_r_q >> RCP_SHIFT);

endmodule

[src/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 box blur: sequencer, line stores, result register.
`timescale 1ns / 1ps

// Streaming 3x3 mean blur of 8-bit BGR pixels in raster order. Each accepted
// item is one pixel; it causes zero to four blurred results, each tagged with
// its row and column, the last one marked by run_last. An item goes through a
// read of the line stores, then per result it releases a sum, a multiply and a
// load of the result register, which waits while a held result is not taken on
// out_ready_i; every result goes through the single shared sum/divide path.
// in_ready_o is high while the sequencer is idle, also while the last result
// still waits to be taken. The two line stores are MAX_WIDTH x 24-bit RAMs
// with no clearing pass: entries not yet written in a frame are masked out of
// every mean. A write to either configuration register restarts the frame at
// row 0, col 0.
module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bbr_pkg::bbr_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output bbr_pkg::bbr_out_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbr_pkg::CFG_W-1:0]          cfg_data_i
);
  import bbr_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_PUT
  } state_e;

  state_e           state_q;
  logic [3:0]       mask_q;
  logic [3:0]       mask_d;
  logic [3:0]       mask_clr;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [CFG_W-1:0] cfg_width_q;
  logic [CFG_W-1:0] cfg_height_q;
  logic             out_valid_q;
  bbr_out_t         out_data_q;

  pix_t             px_q;
  logic [ROW_W-1:0] item_row_q;
  logic [COL_W-1:0] item_col_q;
  logic [ROW_W-1:0] res_row_q;
  logic [COL_W-1:0] res_col_q;
  logic             res_last_q;

  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;
  logic             in_acc;
  logic             out_free;
  logic             cfg_hit;
  logic             up_row;
  logic             left_col;
  win_ctrl_t        win_ctrl;
  pix_t             up_rdata;
  pix_t             mid_rdata;
  sum_t             win_sum;
  pix_t             mean;

  // Clamp the frame size to what the line stores and counters can hold
  always_comb begin
    if (cfg_width_q == '0) begin
      last_col = '0;
    end else if (int'(cfg_width_q) > int'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(cfg_width_q - CFG_W'(1));
    end
    if (cfg_height_q == '0) begin
      last_row = '0;
    end else if (int'(cfg_height_q) > int'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(cfg_height_q - CFG_W'(1));
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cfg_hit    = cfg_we_i &&
                      (cfg_idx_i == CFG_FRAME_WIDTH || cfg_idx_i == CFG_FRAME_HEIGHT);

  // Results the item releases, in release order
  always_comb begin
    mask_d[0] = (item_row_q != '0) && (item_col_q != '0);
    mask_d[1] = (item_row_q != '0) && (item_col_q == last_col);
    mask_d[2] = (item_row_q == last_row) && (item_col_q != '0);
    mask_d[3] = (item_row_q == last_row) && (item_col_q == last_col);
  end

  // Pick the earliest pending result and drop it from the mask
  always_comb begin
    mask_clr = mask_q;
    up_row   = 1'b0;
    left_col = 1'b0;
    if (mask_q[0]) begin
      up_row      = 1'b1;
      left_col    = 1'b1;
      mask_clr[0] = 1'b0;
    end else if (mask_q[1]) begin
      up_row      = 1'b1;
      mask_clr[1] = 1'b0;
    end else if (mask_q[2]) begin
      left_col    = 1'b1;
      mask_clr[2] = 1'b0;
    end else begin
      mask_clr[3] = 1'b0;
    end
  end

  always_comb begin
    win_ctrl.shift_en = (state_q == ST_READ);
    win_ctrl.sum_en   = (state_q == ST_SUM);
    win_ctrl.up_row   = up_row;
    win_ctrl.left_col = left_col;
    win_ctrl.row_ge1  = (item_row_q != '0);
    win_ctrl.row_ge2  = (item_row_q > ROW_W'(1));
    win_ctrl.col_ge1  = (item_col_q != '0);
    win_ctrl.col_ge2  = (item_col_q > COL_W'(1));
  end

  // Sequencer, position counters, configuration and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mask_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
      cfg_width_q  <= RST_FRAME_WIDTH;
      cfg_height_q <= RST_FRAME_HEIGHT;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_hit) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) begin
          cfg_width_q <= cfg_data_i;
        end else begin
          cfg_height_q <= cfg_data_i;
        end
        row_q <= '0;
        col_q <= '0;
      end else if (in_acc) begin
        if (col_q == last_col) begin
          col_q <= '0;
          row_q <= (row_q == last_row) ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end

      if (state_q == ST_PUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          mask_q  <= mask_d;
          state_q <= (mask_d == '0) ? ST_IDLE : ST_SUM;
        end
        ST_SUM: begin
          mask_q  <= mask_clr;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_PUT;
        end
        ST_PUT: begin
          if (out_free) begin
            state_q <= (mask_q == '0) ? ST_IDLE : ST_SUM;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q.blue  <= in_data_i.in_blue;
      px_q.green <= in_data_i.in_green;
      px_q.red   <= in_data_i.in_red;
      item_row_q <= row_q;
      item_col_q <= col_q;
    end
    if (state_q == ST_SUM) begin
      res_row_q  <= item_row_q - ROW_W'(up_row);
      res_col_q  <= item_col_q - COL_W'(left_col);
      res_last_q <= (mask_clr == '0);
    end
    if (state_q == ST_PUT && out_free) begin
      out_data_q.out_row   <= res_row_q;
      out_data_q.out_col   <= OUT_COL_W'(res_col_q);
      out_data_q.out_blue  <= mean.blue;
      out_data_q.out_green <= mean.green;
      out_data_q.out_red   <= mean.red;
      out_data_q.run_last  <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Line stores: read at the item's column when it is accepted, written back in the next cycle
  bbr_ram #(
    .WIDTH($bits(pix_t)),
    .DEPTH(MAX_WIDTH)
  ) u_upper (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_READ),
    .waddr_i(item_col_q),
    .wdata_i(mid_rdata),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(up_rdata)
  );

  bbr_ram #(
    .WIDTH($bits(pix_t)),
    .DEPTH(MAX_WIDTH)
  ) u_middle (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_READ),
    .waddr_i(item_col_q),
    .wdata_i(px_q),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(mid_rdata)
  );

  bbr_window u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(win_ctrl),
    .up_i  (up_rdata),
    .mid_i (mid_rdata),
    .px_i  (px_q),
    .sum_o (win_sum)
  );

  bbr_mean u_mean (
    .clk_i (clk_i),
    .en_i  (state_q == ST_MUL),
    .sum_i (win_sum),
    .mean_o(mean)
  );

endmodule

[src/bbr_checker.sv]
// Port-level assertions for the box blur, bound to the top level.
`timescale 1ns / 1ps

module bbr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input bbr_pkg::bbr_out_t             out_data_o
);
  import bbr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Drop ready after an accepted item while its line stores are read
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted item");

  // No new result right after an item is accepted
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too soon after an item");

  // Keep input blocked while a result that is not the last of its run is taken
  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.run_last |-> !in_ready_o)
    else $error("new item accepted in the middle of a result run");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);
